>>> rtl/core/pbpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pbpm_pkg;

  localparam int FRAME_COUNT = 64;
  localparam int FRAME_W   = $clog2(FRAME_COUNT);
  localparam int CNT_W     = $clog2(FRAME_COUNT + 1);
  localparam int PID_W     = 31;
  localparam int PIN_W     = 16;
  localparam int ICNT_W    = 7;
  localparam int INUM_W    = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_INSTANCE_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INSTANCE_NUMBER = 1'b1;

  typedef enum logic [2:0] {
    REQ_NEW       = 3'd0,
    REQ_FETCH     = 3'd1,
    REQ_UNPIN     = 3'd2,
    REQ_DELETE    = 3'd3,
    REQ_FLUSH     = 3'd4,
    REQ_FLUSH_ALL = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NOT_RESIDENT = 3'd1,
    ST_NO_FRAME     = 3'd2,
    ST_PINNED       = 3'd3,
    ST_NOT_PINNED   = 3'd4,
    ST_PIN_LIMIT    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_HIT_RD,
    S_HIT_EX,
    S_TK_SEL,
    S_TK_DO
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/page_buffer_pool_manager.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                      Payload
// request   start in, busy out             req_type, page_id, mark_dirty
// result    result_valid out (one cycle)   status, frame, page_id_out, write_back,
//                                          write_back_page, load_from_storage, last
// config    cfg_we in                      cfg_index, cfg_data
//
// Lookups scan the tag memory one frame a cycle: a fetch, unpin, delete or flush
// stops at a hit or at the last frame, and new page skips the scan. Flush-all gives
// at most one result a cycle. The scan sets the rate.
// Reset is synchronous; state is ready the cycle after it, no clearing pass.
// The receiver cannot stall; results are presented for exactly one cycle.

module page_buffer_pool_manager (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [2:0]                       req_type,
  input  wire logic [pbpm_pkg::PID_W-1:0]       page_id,
  input  wire logic                             mark_dirty,
  output logic                                  result_valid,
  output logic [2:0]                            status,
  output logic [pbpm_pkg::FRAME_W-1:0]          frame,
  output logic [pbpm_pkg::PID_W-1:0]            page_id_out,
  output logic                                  write_back,
  output logic [pbpm_pkg::PID_W-1:0]            write_back_page,
  output logic                                  load_from_storage,
  output logic                                  last,
  input  wire logic                             cfg_we,
  input  wire logic [pbpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pbpm_pkg::CFG_W-1:0]       cfg_data
);

  localparam int N  = pbpm_pkg::FRAME_COUNT;
  localparam int FW = pbpm_pkg::FRAME_W;
  localparam int CW = pbpm_pkg::CNT_W;
  localparam int PW = pbpm_pkg::PID_W;
  localparam int NW = pbpm_pkg::PIN_W;
  localparam logic [FW-1:0] LAST_FRAME = FW'(N - 1);
  localparam logic [NW-1:0] PIN_MAX    = '1;

  pbpm_pkg::state_t state, state_next;
  pbpm_pkg::req_t   req_q, req_next;
  logic [PW-1:0] pid_q, pid_next;
  logic          mark_q, mark_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          rd_vld, rd_vld_next;
  logic [FW-1:0] rd_frame, rd_frame_next;
  logic [FW-1:0] hf, hf_next;
  logic          take_lru, take_lru_next;

  logic [N-1:0]  resident, resident_next;
  logic [N-1:0]  dirty, dirty_next;
  logic [N-1:0]  member, member_next;
  logic [N-1:0]  fifo_wr, fifo_wr_next;
  logic [FW-1:0] free_head, free_head_next;
  logic [CW-1:0] free_count, free_count_next;
  logic [FW-1:0] lru_head, lru_head_next;
  logic [FW-1:0] lru_tail, lru_tail_next;
  logic [CW-1:0] lru_count, lru_count_next;
  logic [PW-1:0] next_page, next_page_next;
  logic [pbpm_pkg::ICNT_W-1:0] inst_count, inst_count_next;

  logic          res_valid_next;
  logic [2:0]    res_status_next;
  logic [FW-1:0] res_frame_next;
  logic [PW-1:0] res_pid_next;
  logic          res_wb_next;
  logic [PW-1:0] res_wbp_next;
  logic          res_load_next;
  logic          res_last_next;

  logic [PW-1:0] tag_mem [N];
  logic [NW-1:0] pin_mem [N];
  logic [FW-1:0] nxt_mem [N];
  logic [FW-1:0] prv_mem [N];
  logic [FW-1:0] fifo_mem [N];

  logic [PW-1:0] tag_rd;
  logic [NW-1:0] pin_rd;
  logic [FW-1:0] nxt_rd, prv_rd, fifo_rd;
  logic [FW-1:0] tag_raddr, nxt_raddr;

  logic          tag_we, pin_we, nxt_we, prv_we, fifo_we;
  logic [FW-1:0] tag_waddr, pin_waddr, nxt_waddr, prv_waddr, fifo_waddr;
  logic [PW-1:0] tag_wdata;
  logic [NW-1:0] pin_wdata;
  logic [FW-1:0] nxt_wdata, prv_wdata, fifo_wdata;

  logic          lru_rm, lru_add;
  logic [N-1:0]  above;
  logic [FW-1:0] tk_frame;
  logic [PW-1:0] tk_id;

  assign busy      = (state != pbpm_pkg::S_IDLE);
  assign tag_raddr = (state == pbpm_pkg::S_TK_SEL) ? lru_head : cnt[FW-1:0];
  assign nxt_raddr = (state == pbpm_pkg::S_TK_SEL) ? lru_head : hf;
  assign above     = resident >> rd_frame;
  assign tk_frame  = take_lru ? lru_head : (fifo_wr[free_head] ? fifo_rd : free_head);
  assign tk_id     = (req_q == pbpm_pkg::REQ_NEW) ? next_page : pid_q;

  always_ff @(posedge clk) begin
    tag_rd  <= tag_mem[tag_raddr];
    pin_rd  <= pin_mem[hf];
    nxt_rd  <= nxt_mem[nxt_raddr];
    prv_rd  <= prv_mem[hf];
    fifo_rd <= fifo_mem[free_head];
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_wdata;
    end
    if (pin_we) begin
      pin_mem[pin_waddr] <= pin_wdata;
    end
    if (nxt_we) begin
      nxt_mem[nxt_waddr] <= nxt_wdata;
    end
    if (prv_we) begin
      prv_mem[prv_waddr] <= prv_wdata;
    end
    if (fifo_we) begin
      fifo_mem[fifo_waddr] <= fifo_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pbpm_pkg::S_IDLE;
      rd_vld       <= 1'b0;
      resident     <= '0;
      dirty        <= '0;
      member       <= '0;
      fifo_wr      <= '0;
      free_head    <= '0;
      free_count   <= CW'(N);
      lru_count    <= '0;
      next_page    <= '0;
      inst_count   <= pbpm_pkg::ICNT_W'(1);
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      rd_vld       <= rd_vld_next;
      resident     <= resident_next;
      dirty        <= dirty_next;
      member       <= member_next;
      fifo_wr      <= fifo_wr_next;
      free_head    <= free_head_next;
      free_count   <= free_count_next;
      lru_count    <= lru_count_next;
      next_page    <= next_page_next;
      inst_count   <= inst_count_next;
      result_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    req_q             <= req_next;
    pid_q             <= pid_next;
    mark_q            <= mark_next;
    cnt               <= cnt_next;
    rd_frame          <= rd_frame_next;
    hf                <= hf_next;
    take_lru          <= take_lru_next;
    lru_head          <= lru_head_next;
    lru_tail          <= lru_tail_next;
    status            <= res_status_next;
    frame             <= res_frame_next;
    page_id_out       <= res_pid_next;
    write_back        <= res_wb_next;
    write_back_page   <= res_wbp_next;
    load_from_storage <= res_load_next;
    last              <= res_last_next;
  end

  always_comb begin
    state_next      = state;
    req_next        = req_q;
    pid_next        = pid_q;
    mark_next       = mark_q;
    cnt_next        = cnt;
    rd_vld_next     = 1'b0;
    rd_frame_next   = rd_frame;
    hf_next         = hf;
    take_lru_next   = take_lru;
    resident_next   = resident;
    dirty_next      = dirty;
    member_next     = member;
    fifo_wr_next    = fifo_wr;
    free_head_next  = free_head;
    free_count_next = free_count;
    lru_head_next   = lru_head;
    lru_tail_next   = lru_tail;
    lru_count_next  = lru_count;
    next_page_next  = next_page;
    inst_count_next = inst_count;
    lru_rm          = 1'b0;
    lru_add         = 1'b0;

    tag_we = 1'b0;  tag_waddr = tk_frame;  tag_wdata = tk_id;
    pin_we = 1'b0;  pin_waddr = hf;        pin_wdata = '0;
    nxt_we = 1'b0;  nxt_waddr = prv_rd;    nxt_wdata = nxt_rd;
    prv_we = 1'b0;  prv_waddr = nxt_rd;    prv_wdata = prv_rd;
    fifo_we = 1'b0;
    fifo_waddr = free_head + free_count[FW-1:0];
    fifo_wdata = hf;

    res_valid_next  = 1'b0;
    res_status_next = pbpm_pkg::ST_OK;
    res_frame_next  = '0;
    res_pid_next    = '0;
    res_wb_next     = 1'b0;
    res_wbp_next    = '0;
    res_load_next   = 1'b0;
    res_last_next   = 1'b0;

    if (cfg_we) begin
      unique case (cfg_index)
        pbpm_pkg::REG_INSTANCE_COUNT:  inst_count_next = cfg_data[pbpm_pkg::ICNT_W-1:0];
        pbpm_pkg::REG_INSTANCE_NUMBER: next_page_next =
                                         PW'(cfg_data[pbpm_pkg::INUM_W-1:0]);
        default: ;
      endcase
    end

    unique case (state)
      pbpm_pkg::S_IDLE: begin
        if (start) begin
          req_next  = pbpm_pkg::req_t'(req_type);
          pid_next  = page_id;
          mark_next = mark_dirty;
          cnt_next  = '0;
          unique case (req_type)
            pbpm_pkg::REQ_NEW: state_next = pbpm_pkg::S_TK_SEL;
            pbpm_pkg::REQ_FETCH, pbpm_pkg::REQ_UNPIN, pbpm_pkg::REQ_DELETE,
            pbpm_pkg::REQ_FLUSH, pbpm_pkg::REQ_FLUSH_ALL: state_next = pbpm_pkg::S_SCAN;
            default: ;
          endcase
        end
      end

      pbpm_pkg::S_SCAN: begin
        if (cnt < CW'(N)) begin
          rd_vld_next   = 1'b1;
          rd_frame_next = cnt[FW-1:0];
          cnt_next      = cnt + CW'(1);
        end
        if (req_q == pbpm_pkg::REQ_FLUSH_ALL) begin
          if (!rd_vld && cnt == '0 && resident == '0) begin
            res_valid_next = 1'b1;
            res_last_next  = 1'b1;
            state_next     = pbpm_pkg::S_IDLE;
          end else if (rd_vld) begin
            if (resident[rd_frame]) begin
              dirty_next[rd_frame] = 1'b0;
              res_valid_next = 1'b1;
              res_frame_next = rd_frame;
              res_pid_next   = tag_rd;
              res_wb_next    = 1'b1;
              res_wbp_next   = tag_rd;
              res_last_next  = ~|above[N-1:1];
            end
            if (rd_frame == LAST_FRAME) begin
              state_next = pbpm_pkg::S_IDLE;
            end
          end
        end else if (rd_vld && resident[rd_frame] && tag_rd == pid_q) begin
          hf_next    = rd_frame;
          state_next = pbpm_pkg::S_HIT_RD;
        end else if (rd_vld && rd_frame == LAST_FRAME) begin
          if (req_q == pbpm_pkg::REQ_FETCH) begin
            state_next = pbpm_pkg::S_TK_SEL;
          end else begin
            res_valid_next  = 1'b1;
            res_last_next   = 1'b1;
            res_status_next = (req_q == pbpm_pkg::REQ_DELETE) ? pbpm_pkg::ST_OK
                                                              : pbpm_pkg::ST_NOT_RESIDENT;
            state_next      = pbpm_pkg::S_IDLE;
          end
        end
      end

      pbpm_pkg::S_HIT_RD: begin
        state_next = pbpm_pkg::S_HIT_EX;
      end

      pbpm_pkg::S_HIT_EX: begin
        state_next     = pbpm_pkg::S_IDLE;
        res_valid_next = 1'b1;
        res_last_next  = 1'b1;
        res_frame_next = hf;
        res_pid_next   = pid_q;
        case (req_q)
          pbpm_pkg::REQ_FETCH: begin
            lru_rm = 1'b1;
            if (pin_rd == PIN_MAX) begin
              res_status_next = pbpm_pkg::ST_PIN_LIMIT;
            end else begin
              pin_we    = 1'b1;
              pin_wdata = pin_rd + NW'(1);
            end
          end
          pbpm_pkg::REQ_UNPIN: begin
            if (pin_rd == '0) begin
              res_status_next = pbpm_pkg::ST_NOT_PINNED;
            end else begin
              pin_we    = 1'b1;
              pin_wdata = pin_rd - NW'(1);
              lru_add   = (pin_rd == NW'(1)) && !member[hf];
              if (mark_q) begin
                dirty_next[hf] = 1'b1;
              end
            end
          end
          pbpm_pkg::REQ_DELETE: begin
            if (pin_rd != '0) begin
              res_status_next = pbpm_pkg::ST_PINNED;
            end else begin
              res_pid_next      = '0;
              res_wb_next       = dirty[hf];
              res_wbp_next      = dirty[hf] ? pid_q : '0;
              resident_next[hf] = 1'b0;
              dirty_next[hf]    = 1'b0;
              lru_rm            = 1'b1;
              if (free_count < CW'(N)) begin
                fifo_we                 = 1'b1;
                fifo_wr_next[fifo_waddr] = 1'b1;
                free_count_next         = free_count + CW'(1);
              end
            end
          end
          default: begin
            dirty_next[hf] = 1'b0;
            res_wb_next    = 1'b1;
            res_wbp_next   = pid_q;
          end
        endcase
      end

      pbpm_pkg::S_TK_SEL: begin
        if (free_count != '0) begin
          take_lru_next = 1'b0;
          state_next    = pbpm_pkg::S_TK_DO;
        end else if (lru_count != '0) begin
          take_lru_next = 1'b1;
          state_next    = pbpm_pkg::S_TK_DO;
        end else begin
          res_valid_next  = 1'b1;
          res_last_next   = 1'b1;
          res_status_next = pbpm_pkg::ST_NO_FRAME;
          state_next      = pbpm_pkg::S_IDLE;
        end
      end

      pbpm_pkg::S_TK_DO: begin
        if (take_lru) begin
          lru_head_next        = nxt_rd;
          lru_count_next       = lru_count - CW'(1);
          member_next[lru_head] = 1'b0;
          res_wb_next          = dirty[lru_head];
          res_wbp_next         = dirty[lru_head] ? tag_rd : '0;
        end else begin
          free_head_next  = free_head + FW'(1);
          free_count_next = free_count - CW'(1);
        end
        tag_we                  = 1'b1;
        pin_we                  = 1'b1;
        pin_waddr               = tk_frame;
        pin_wdata               = NW'(1);
        resident_next[tk_frame] = 1'b1;
        dirty_next[tk_frame]    = 1'b0;
        if (req_q == pbpm_pkg::REQ_NEW) begin
          next_page_next = next_page + PW'(inst_count);
        end
        res_valid_next = 1'b1;
        res_last_next  = 1'b1;
        res_frame_next = tk_frame;
        res_pid_next   = tk_id;
        res_load_next  = (req_q == pbpm_pkg::REQ_FETCH);
        state_next     = pbpm_pkg::S_IDLE;
      end

      default: state_next = pbpm_pkg::S_IDLE;
    endcase

    // unlink hf from the LRU list
    if (lru_rm && member[hf]) begin
      if (hf == lru_head) begin
        lru_head_next = nxt_rd;
      end else begin
        nxt_we = 1'b1;
      end
      if (hf == lru_tail) begin
        lru_tail_next = prv_rd;
      end else begin
        prv_we = 1'b1;
      end
      lru_count_next  = lru_count - CW'(1);
      member_next[hf] = 1'b0;
    end

    // append hf at the LRU tail
    if (lru_add) begin
      if (lru_count == '0) begin
        lru_head_next = hf;
      end else begin
        nxt_we    = 1'b1;
        nxt_waddr = lru_tail;
        nxt_wdata = hf;
      end
      prv_we          = 1'b1;
      prv_waddr       = hf;
      prv_wdata       = lru_tail;
      lru_tail_next   = hf;
      lru_count_next  = lru_count + CW'(1);
      member_next[hf] = 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_member_count: assert property (@(posedge clk) disable iff (rst)
    $countones(member) == int'(lru_count))
    else $error("LRU membership and count disagree");

  a_frames_bounded: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, free_count} + {1'b0, lru_count}) <= (CW + 1)'(N))
    else $error("free and LRU frames exceed pool");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without a request in progress");

  a_member_resident: assert property (@(posedge clk) disable iff (rst)
    (member & ~resident) == '0)
    else $error("LRU holds a frame that is not resident");
`endif

endmodule

`default_nettype wire
